### rtl/assert_macros.svh
// Assertion macros used by the frame size scanner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/jfss_pkg.sv
// Types and constants for the JPEG frame size scanner.
`timescale 1ns / 1ps
`default_nettype none

package jfss_pkg;

  localparam logic [7:0] MARKER_PREFIX = 8'hFF;
  localparam logic [7:0] MARKER_RST_LO = 8'hD0;
  localparam logic [7:0] MARKER_RST_HI = 8'hD9;
  localparam logic [7:0] MARKER_SOF0   = 8'hC0;

  typedef enum logic [3:0] {
    PH_PREFIX = 4'd0,
    PH_MARKER = 4'd1,
    PH_LEN_HI = 4'd2,
    PH_LEN_LO = 4'd3,
    PH_SKIP   = 4'd4,
    PH_SOF_L1 = 4'd5,
    PH_SOF_L2 = 4'd6,
    PH_SOF_P  = 4'd7,
    PH_H_HI   = 4'd8,
    PH_H_LO   = 4'd9,
    PH_W_HI   = 4'd10,
    PH_W_LO   = 4'd11
  } phase_t;

  typedef struct packed {
    logic        found;
    logic [15:0] height;
    logic [15:0] width;
  } result_t;

endpackage

`default_nettype wire

### rtl/jpeg_frame_size_scanner.sv
// JPEG frame size scanner: walks marker segments and reports the SOF0 frame size.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   Input channel (in_valid / in_stall): one payload byte per beat on in_data_byte,
//   in_last_byte high on the final byte of an image. Output channel (out_valid /
//   out_stall): one beat per image, out_found with out_image_height/out_image_width
//   on success, or out_found low with zero sizes on a bad prefix, a segment length
//   below two, or the end of the payload before the SOF0 frame size was read.
//   Throughput: one byte per cycle while in_stall is low. The byte walk is a single
//   phase register updated once per byte, so it does not limit the rate below that.
//   Result path: a result is registered into the output register when the byte
//   that decides it is accepted, or into the skid register if a result is stalled.
//   Stall: a two-entry output (output register plus skid register) keeps bytes
//   flowing while a result waits; in_stall rises only when both entries are full,
//   i.e. a second result arrived while the first is still stalled.
//   Bytes after the decision are dropped until the final byte of the image.
//   Reset: a synchronous rst_n low returns the parser to expecting the 0xFF
//   prefix and empties both output entries; there is no clearing pass.
module jpeg_frame_size_scanner (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic        out_found,
  output      logic [15:0] out_image_height,
  output      logic [15:0] out_image_width
);
  import jfss_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [15:0] skip_r, skip_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [15:0] height_r, height_nxt;
  logic [7:0]  width_hi_r, width_hi_nxt;
  logic        settled_r, settled_nxt;

  logic        emit;
  result_t     res;
  logic [15:0] seg_len;
  logic        in_acc;

  result_t     out_r, skid_r;
  logic        out_valid_r, skid_valid_r;
  logic        out_take;

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;
  assign seg_len  = {len_hi_r, in_data_byte};

  always_comb begin
    phase_nxt    = phase_r;
    skip_nxt     = skip_r;
    len_hi_nxt   = len_hi_r;
    height_nxt   = height_r;
    width_hi_nxt = width_hi_r;
    settled_nxt  = settled_r;
    emit         = 1'b0;
    res          = '0;
    if (!settled_r) begin
      unique case (phase_r)
        PH_PREFIX: begin
          if (in_data_byte != MARKER_PREFIX) emit = 1'b1;
          else phase_nxt = PH_MARKER;
        end
        PH_MARKER: begin
          if (in_data_byte >= MARKER_RST_LO && in_data_byte <= MARKER_RST_HI) begin
            phase_nxt = PH_PREFIX;
          end else if (in_data_byte == MARKER_SOF0) begin
            phase_nxt = PH_SOF_L1;
          end else begin
            phase_nxt = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          len_hi_nxt = in_data_byte;
          phase_nxt  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          // length counts its own two bytes
          if (seg_len[15:1] == 15'd0) begin
            emit = 1'b1;
          end else begin
            skip_nxt  = seg_len - 16'd2;
            phase_nxt = (seg_len == 16'd2) ? PH_PREFIX : PH_SKIP;
          end
        end
        PH_SKIP: begin
          skip_nxt = skip_r - 16'd1;
          if (skip_r == 16'd1) phase_nxt = PH_PREFIX;
        end
        PH_SOF_L1: phase_nxt = PH_SOF_L2;
        PH_SOF_L2: phase_nxt = PH_SOF_P;
        PH_SOF_P:  phase_nxt = PH_H_HI;
        PH_H_HI: begin
          height_nxt = {in_data_byte, 8'd0};
          phase_nxt  = PH_H_LO;
        end
        PH_H_LO: begin
          height_nxt = {height_r[15:8], in_data_byte};
          phase_nxt  = PH_W_HI;
        end
        PH_W_HI: begin
          width_hi_nxt = in_data_byte;
          phase_nxt    = PH_W_LO;
        end
        PH_W_LO: begin
          emit       = 1'b1;
          res.found  = 1'b1;
          res.height = height_r;
          res.width  = {width_hi_r, in_data_byte};
        end
        default: emit = 1'b1;
      endcase
    end
    if (emit) settled_nxt = 1'b1;
    if (in_last_byte) begin
      // end of payload: fail if still undecided, then start over
      if (!settled_nxt) begin
        emit = 1'b1;
        res  = '0;
      end
      phase_nxt    = PH_PREFIX;
      skip_nxt     = 16'd0;
      len_hi_nxt   = 8'd0;
      height_nxt   = 16'd0;
      width_hi_nxt = 8'd0;
      settled_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_PREFIX;
      skip_r     <= 16'd0;
      len_hi_r   <= 8'd0;
      height_r   <= 16'd0;
      width_hi_r <= 8'd0;
      settled_r  <= 1'b0;
    end else if (in_acc) begin
      phase_r    <= phase_nxt;
      skip_r     <= skip_nxt;
      len_hi_r   <= len_hi_nxt;
      height_r   <= height_nxt;
      width_hi_r <= width_hi_nxt;
      settled_r  <= settled_nxt;
    end
  end

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        if (out_take || !out_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end
      end else if (in_acc && emit) begin
        if (out_take || !out_valid_r) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take || !out_valid_r) out_r <= skid_r;
    end else if (in_acc && emit) begin
      if (out_take || !out_valid_r) out_r <= res;
      else skid_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_r.found;
  assign out_image_height = out_r.height;
  assign out_image_width  = out_r.width;

`include "assert_macros.svh"

  `ASSERT_CLK_RST(a_skid_needs_out, clk, rst_n,
    !skid_valid_r || out_valid_r, "skid full with output empty")
  `ASSERT_CLK_RST(a_skid_holds, clk, rst_n,
    (skid_valid_r && out_stall) |=> skid_valid_r, "skid beat dropped while stalled")
  `ASSERT_CLK_RST(a_found_phase, clk, rst_n,
    (emit && res.found) |-> (phase_r == PH_W_LO && !settled_r),
    "found result outside width phase")
  `ASSERT_CLK_RST(a_no_emit_settled, clk, rst_n,
    (settled_r && !in_last_byte) |-> !emit, "second result for one image")

endmodule

`default_nettype wire

### tb/jpeg_frame_size_scanner_tb.sv
`timescale 1ns / 1ps
// Testbench for the JPEG frame size scanner: byte stream driver, result monitor, frame size check.
module jpeg_frame_size_scanner_tb;
  import jfss_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int STREAM_TARGET = 1250;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } payload_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_found;
  logic [15:0] out_image_height;
  logic [15:0] out_image_width;

  payload_beat_t byte_stream_q[$];
  result_t       frame_size_q[$];
  logic [7:0]    image_buf[$];

  int cycle_cnt = 0;
  int mismatch_cnt = 0;
  int beats_taken = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int stall_mode = 0;
  int mode_left = 0;

  // Predictor state for the segment walk
  phase_t      scan_phase;
  logic [15:0] skip_left;
  logic [7:0]  len_hi_q;
  logic [15:0] height_acc;
  logic [7:0]  width_hi_q;
  logic        decided;

  jpeg_frame_size_scanner DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_found        (out_found),
    .out_image_height (out_image_height),
    .out_image_width  (out_image_width)
  );

  always #6 clk = ~clk;

  task automatic clear_scan_state();
    scan_phase = PH_PREFIX;
    skip_left  = '0;
    len_hi_q   = '0;
    height_acc = '0;
    width_hi_q = '0;
    decided    = 1'b0;
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic last);
    logic [15:0] seg_len;
    logic        got;
    result_t     r;
    got = 1'b0;
    r = '0;
    if (!decided) begin
      case (scan_phase)
        PH_PREFIX: begin
          if (b != MARKER_PREFIX) got = 1'b1;
          else scan_phase = PH_MARKER;
        end
        PH_MARKER: begin
          if (b >= MARKER_RST_LO && b <= MARKER_RST_HI) scan_phase = PH_PREFIX;
          else if (b == MARKER_SOF0) scan_phase = PH_SOF_L1;
          else scan_phase = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_hi_q = b;
          scan_phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          seg_len = {len_hi_q, b};
          if (seg_len < 16'd2) begin
            got = 1'b1;
          end else begin
            skip_left = seg_len - 16'd2;
            scan_phase = (skip_left == 16'd0) ? PH_PREFIX : PH_SKIP;
          end
        end
        PH_SKIP: begin
          skip_left = skip_left - 16'd1;
          if (skip_left == 16'd0) scan_phase = PH_PREFIX;
        end
        PH_SOF_L1: scan_phase = PH_SOF_L2;
        PH_SOF_L2: scan_phase = PH_SOF_P;
        PH_SOF_P:  scan_phase = PH_H_HI;
        PH_H_HI: begin
          height_acc = {b, 8'h00};
          scan_phase = PH_H_LO;
        end
        PH_H_LO: begin
          height_acc = height_acc | {8'h00, b};
          scan_phase = PH_W_HI;
        end
        PH_W_HI: begin
          width_hi_q = b;
          scan_phase = PH_W_LO;
        end
        PH_W_LO: begin
          got = 1'b1;
          r.found = 1'b1;
          r.height = height_acc;
          r.width = {width_hi_q, b};
        end
        default: got = 1'b1;
      endcase
    end
    if (got) decided = 1'b1;
    if (last) begin
      // end of payload with nothing decided yet reports a failure
      if (!decided) begin
        got = 1'b1;
        r = '0;
      end
      clear_scan_state();
    end
    if (got) frame_size_q.push_back(r);
  endtask

  // Image assembly
  task automatic put(input logic [7:0] b);
    image_buf.push_back(b);
  endtask

  function automatic logic [7:0] pick_skip_marker();
    logic [7:0] m;
    if ($urandom_range(0, 7) == 0) return MARKER_PREFIX;
    m = MARKER_SOF0;
    while (m == MARKER_SOF0 || (m >= MARKER_RST_LO && m <= MARKER_RST_HI))
      m = 8'($urandom_range(0, 255));
    return m;
  endfunction

  task automatic add_skip_segment(input logic [7:0] marker, input logic [15:0] seg_len);
    put(MARKER_PREFIX);
    put(marker);
    put(seg_len[15:8]);
    put(seg_len[7:0]);
    for (int i = 2; i < seg_len; i++) put(8'($urandom_range(0, 255)));
  endtask

  task automatic add_sof0(input logic [15:0] h, input logic [15:0] w);
    put(MARKER_PREFIX);
    put(MARKER_SOF0);
    put(8'($urandom_range(0, 255)));
    put(8'($urandom_range(0, 255)));
    put(8'($urandom_range(0, 255)));
    put(h[15:8]);
    put(h[7:0]);
    put(w[15:8]);
    put(w[7:0]);
  endtask

  task automatic add_leading_segments();
    int n;
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) == 0) begin
        put(MARKER_PREFIX);
        put(8'($urandom_range(MARKER_RST_LO, MARKER_RST_HI)));
      end else begin
        add_skip_segment(pick_skip_marker(), 16'($urandom_range(2, 12)));
      end
    end
  endtask

  task automatic add_trailing_bytes(input int max_n);
    int n;
    n = $urandom_range(0, max_n);
    for (int i = 0; i < n; i++) put(8'($urandom_range(0, 255)));
  endtask

  function automatic logic [15:0] pick_dim();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Move the assembled image into the stream, flag on its final byte
  task automatic commit_image();
    payload_beat_t beat;
    for (int i = 0; i < image_buf.size(); i++) begin
      beat.data = image_buf[i];
      beat.last = (i == image_buf.size() - 1);
      byte_stream_q.push_back(beat);
    end
    image_buf.delete();
  endtask

  task automatic add_random_image();
    int kind;
    int cut;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      add_leading_segments();
      add_sof0(pick_dim(), pick_dim());
      add_trailing_bytes(3);
    end else if (kind < 70) begin
      add_leading_segments();
      add_sof0(pick_dim(), pick_dim());
      cut = $urandom_range(1, image_buf.size() - 1);
      while (image_buf.size() > cut) void'(image_buf.pop_back());
    end else if (kind < 80) begin
      add_leading_segments();
      put(8'($urandom_range(0, 254)));
      add_trailing_bytes(3);
    end else if (kind < 88) begin
      add_leading_segments();
      put(MARKER_PREFIX);
      put(pick_skip_marker());
      put(8'h00);
      put(8'($urandom_range(0, 1)));
      add_trailing_bytes(3);
    end else if (kind < 95) begin
      // long segment cut short by the end of the payload
      add_leading_segments();
      put(MARKER_PREFIX);
      put(pick_skip_marker());
      put(8'($urandom_range(1, 255)));
      put(8'($urandom_range(0, 255)));
      add_trailing_bytes(6);
    end else begin
      put(8'($urandom_range(0, 255)));
      add_trailing_bytes(7);
    end
    commit_image();
  endtask

  // Driver: bursts of beats with random gaps
  always @(posedge clk) begin : drive_proc
    payload_beat_t beat;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data_byte <= 8'h00;
      in_last_byte <= 1'b0;
      burst_left <= $urandom_range(1, 48);
      gap_left <= 0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (byte_stream_q.size() != 0) begin
        beat = byte_stream_q.pop_front();
        in_valid <= 1'b1;
        in_data_byte <= beat.data;
        in_last_byte <= beat.last;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 48);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check the result beat, then predict from the input beat
  always @(posedge clk) begin : monitor_proc
    result_t exp_r;
    if (!rst_n) begin
      clear_scan_state();
    end else begin
      if (out_valid && !out_stall) begin
        if (frame_size_q.size() == 0) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < 10)
            $display("unexpected result: found=%0b height=%0d width=%0d",
                     out_found, out_image_height, out_image_width);
        end else begin
          exp_r = frame_size_q.pop_front();
          if (out_found !== exp_r.found || out_image_height !== exp_r.height ||
              out_image_width !== exp_r.width) begin
            mismatch_cnt <= mismatch_cnt + 1;
            if (mismatch_cnt < 10)
              $display({"mismatch: expected found=%0b height=%0d width=%0d, ",
                        "got found=%0b height=%0d width=%0d"},
                       exp_r.found, exp_r.height, exp_r.width,
                       out_found, out_image_height, out_image_width);
          end
        end
      end
      if (in_valid && !in_stall) begin
        scan_byte(in_data_byte, in_last_byte);
        beats_taken <= beats_taken + 1;
      end
    end
  end

  // Long hold-off once, so both result entries fill and the input stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && beats_taken >= 300) begin
      hold_left <= 600;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver stall pattern, switching mode every so often
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_mode <= 0;
      mode_left <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(20, 120);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall <= (hold_left != 0);
        1: out_stall <= (hold_left != 0) || ($urandom_range(0, 3) == 0);
        2: out_stall <= (hold_left != 0) || ($urandom_range(0, 3) != 0);
        default: out_stall <= (hold_left != 0) || (cycle_cnt % 3 == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("jpeg_frame_size_scanner_tb: FAIL");
      $finish;
    end
  end

  initial begin
    // bad prefix at the first byte
    put(8'h00);
    commit_image();
    // payload ends right after the prefix
    put(MARKER_PREFIX);
    commit_image();
    // restart marker, 0xFF marker with empty segment, SOF0 with extreme sizes
    put(MARKER_PREFIX);
    put(MARKER_RST_LO);
    add_skip_segment(MARKER_PREFIX, 16'd2);
    put(MARKER_PREFIX);
    put(MARKER_SOF0);
    put(8'h00);
    put(8'h11);
    put(8'h08);
    put(8'hFF);
    put(8'hFF);
    put(8'h00);
    put(8'h00);
    commit_image();
    // short length, then a byte after the decision
    put(MARKER_PREFIX);
    put(8'hDB);
    put(8'h00);
    put(8'h01);
    put(8'h3C);
    commit_image();

    while (byte_stream_q.size() < STREAM_TARGET) add_random_image();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_stream_q.size() != 0 || in_valid) @(posedge clk);
    while (frame_size_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (mismatch_cnt == 0)
      $display("jpeg_frame_size_scanner_tb: PASS");
    else
      $display("jpeg_frame_size_scanner_tb: FAIL");
    $finish;
  end

endmodule
